FILE: rtl/core/playfield_pixel_color_defines.svh
// ----------------------------------------------------------------------------
// Playfield pixel color assertion macros
// Shared concurrent assertion forms for the playfield pixel color pipeline.
// ----------------------------------------------------------------------------
`ifndef PLAYFIELD_PIXEL_COLOR_DEFINES_SVH
`define PLAYFIELD_PIXEL_COLOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pfpc_pkg.sv
// ----------------------------------------------------------------------------
// Playfield pixel color package
// Widths, line geometry, register indexes, hue codes and the luma tables of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpc_pkg;

	localparam int unsigned LINE_PIXELS   = 160;
	localparam int unsigned HALF_PIXELS   = 80;
	localparam int unsigned BITS_PER_HALF = 20;

	localparam int COLUMN_W = 8;
	localparam int INDEX_W  = 5;
	localparam int CODE_W   = 8;
	localparam int CHAN_W   = 8;
	localparam int HUE_W    = 4;
	localparam int LUMA_W   = 3;

	localparam logic [2:0] REG_PATTERN_LEFT   = 3'd0;
	localparam logic [2:0] REG_PATTERN_MIDDLE = 3'd1;
	localparam logic [2:0] REG_PATTERN_RIGHT  = 3'd2;
	localparam logic [2:0] REG_MIRROR         = 3'd3;
	localparam logic [2:0] REG_BACKGROUND     = 3'd4;
	localparam logic [2:0] REG_FOREGROUND     = 3'd5;

	typedef logic [COLUMN_W-1:0] column_t;
	typedef logic [INDEX_W-1:0]  index_t;
	typedef logic [CODE_W-1:0]   code_t;
	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [LUMA_W-1:0]   luma_t;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] middle;
		logic [7:0] right;
	} pattern_t;

	typedef enum logic [HUE_W-1:0] {
		HUE_AMBER   = 4'd0,
		HUE_ORANGE  = 4'd1,
		HUE_YELLOW  = 4'd2,
		HUE_LIME    = 4'd3,
		HUE_GREEN   = 4'd4,
		HUE_SPRING  = 4'd5,
		HUE_CYAN    = 4'd6,
		HUE_AZURE   = 4'd7,
		HUE_BLUE    = 4'd8,
		HUE_VIOLET  = 4'd9,
		HUE_MAGENTA = 4'd10,
		HUE_ROSE    = 4'd11,
		HUE_RED     = 4'd12,
		HUE_CORAL   = 4'd13,
		HUE_SCARLET = 4'd14,
		HUE_GOLD    = 4'd15
	} hue_t;

	localparam chan_t LEVEL_BASE = 8'd32;

	// Full intensity of a luma step: 32 + 28 * luma.
	function automatic chan_t luma_level(input luma_t luma);
		chan_t level;
		unique case (luma)
			3'd0: level = 8'd32;
			3'd1: level = 8'd60;
			3'd2: level = 8'd88;
			3'd3: level = 8'd116;
			3'd4: level = 8'd144;
			3'd5: level = 8'd172;
			3'd6: level = 8'd200;
			3'd7: level = 8'd228;
			default: level = 8'd32;
		endcase
		return level;
	endfunction

	// Partial intensity of a luma step: level * (80 or 200) / 255, truncated.
	function automatic chan_t luma_partial(input luma_t luma);
		chan_t part;
		unique case (luma)
			3'd0: part = 8'd10;
			3'd1: part = 8'd18;
			3'd2: part = 8'd69;
			3'd3: part = 8'd90;
			3'd4: part = 8'd112;
			3'd5: part = 8'd134;
			3'd6: part = 8'd156;
			3'd7: part = 8'd178;
			default: part = 8'd10;
		endcase
		return part;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfpc_locate.sv
// ----------------------------------------------------------------------------
// Playfield pixel locate stage
// Maps a column to its pattern bit index, with the right half repeated or mirrored.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_locate (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pfpc_pkg::column_t column,
	input  wire logic             mirror,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pfpc_pkg::index_t      index_s1,
	output logic                  on_line_s1
);
	import pfpc_pkg::*;

	logic     valid_s1;
	logic     right_half;
	logic [6:0] offset;
	index_t   base_index;
	index_t   next_index;

	always_comb begin
		right_half = column >= COLUMN_W'(HALF_PIXELS);
		offset     = right_half ? 7'(column - COLUMN_W'(HALF_PIXELS)) : column[6:0];
		base_index = offset[6:2];
		next_index = (right_half && mirror) ? INDEX_W'(BITS_PER_HALF - 1) - base_index
		                                    : base_index;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			index_s1   <= next_index;
			on_line_s1 <= column < COLUMN_W'(LINE_PIXELS);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pfpc_select.sv
// ----------------------------------------------------------------------------
// Playfield pixel select stage
// Picks the pattern bit and chooses the foreground or background color code.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_select (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pfpc_pkg::index_t   index_s1,
	input  wire logic               on_line_s1,
	input  wire pfpc_pkg::pattern_t pattern,
	input  wire pfpc_pkg::code_t    background_code,
	input  wire pfpc_pkg::code_t    foreground_code,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pfpc_pkg::code_t         code_s2
);
	import pfpc_pkg::*;

	logic                     valid_s2;
	logic [BITS_PER_HALF-1:0] pf_bits;
	logic                     lit;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pf_bits[i] = pattern.left[4 + i];
		end
		for (int i = 4; i < 12; i++) begin
			pf_bits[i] = pattern.middle[11 - i];
		end
		for (int i = 12; i < 20; i++) begin
			pf_bits[i] = pattern.right[i - 12];
		end
		lit = on_line_s1 && pf_bits[index_s1];
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s2 <= lit ? foreground_code : background_code;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pfpc_color.sv
// ----------------------------------------------------------------------------
// Playfield pixel color stages
// Looks up the luma intensities, then forms the RGB channels from the hue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfield_pixel_color_defines.svh"

module pfpc_color (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pfpc_pkg::code_t code_s2,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pfpc_pkg::chan_t      red_s4,
	output pfpc_pkg::chan_t      green_s4,
	output pfpc_pkg::chan_t      blue_s4
);
	import pfpc_pkg::*;

	logic  valid_s3;
	logic  valid_s4;
	logic  ready_s4;
	hue_t  hue_s3;
	chan_t level_s3;
	chan_t part_s3;
	chan_t red_d;
	chan_t green_d;
	chan_t blue_d;

	assign in_ready  = !valid_s3 || ready_s4;
	assign ready_s4  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_s3   <= hue_t'(code_s2[7:4]);
			level_s3 <= luma_level(code_s2[3:1]);
			part_s3  <= luma_partial(code_s2[3:1]);
		end
	end

	always_comb begin
		red_d   = '0;
		green_d = '0;
		blue_d  = '0;
		unique case (hue_s3)
			HUE_AMBER:   begin red_d = level_s3;      green_d = part_s3;        end
			HUE_ORANGE:  begin red_d = level_s3;      green_d = level_s3 >> 1;  end
			HUE_YELLOW:  begin red_d = level_s3;      green_d = level_s3;       end
			HUE_LIME:    begin red_d = part_s3;       green_d = level_s3;       end
			HUE_GREEN:   begin green_d = level_s3;                              end
			HUE_SPRING:  begin green_d = level_s3;    blue_d = level_s3 >> 1;   end
			HUE_CYAN:    begin green_d = level_s3;    blue_d = level_s3;        end
			HUE_AZURE:   begin green_d = part_s3;     blue_d = level_s3;        end
			HUE_BLUE:    begin blue_d = level_s3;                               end
			HUE_VIOLET:  begin red_d = level_s3 >> 1; blue_d = level_s3;        end
			HUE_MAGENTA: begin red_d = level_s3;      blue_d = level_s3;        end
			HUE_ROSE:    begin red_d = level_s3;      blue_d = part_s3;         end
			HUE_RED:     begin red_d = level_s3;                                end
			HUE_CORAL: begin
				red_d   = level_s3;
				green_d = level_s3 >> 2;
				blue_d  = level_s3 >> 3;
			end
			HUE_SCARLET: begin
				red_d   = level_s3;
				green_d = level_s3 >> 3;
				blue_d  = level_s3 >> 4;
			end
			HUE_GOLD:    begin red_d = level_s3;      green_d = part_s3 >> 1;   end
			default:     begin red_d = level_s3;      green_d = part_s3 >> 1;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			red_s4   <= red_d;
			green_s4 <= green_d;
			blue_s4  <= blue_d;
		end
	end

	`PFPC_ASSERT_IMPLY(a_luma_range, clk, arst_n, valid_s3,
		(level_s3 >= LEVEL_BASE) && (part_s3 < level_s3), "luma intensities out of range")
	`PFPC_ASSERT_NEXT(a_s3_hold, clk, arst_n, valid_s3 && !ready_s4,
		valid_s3 && $stable(hue_s3) && $stable(level_s3) && $stable(part_s3),
		"stalled luma stage lost its contents")
	`PFPC_ASSERT_NEXT(a_s4_load, clk, arst_n, valid_s3 && ready_s4, valid_s4,
		"luma stage result did not reach the output stage")

endmodule

`default_nettype wire

FILE: rtl/core/playfield_pixel_color.sv
// ----------------------------------------------------------------------------
// Playfield pixel color generator
// Returns the RGB color of one pixel column from the playfield pattern registers.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                     Payload
//   input     column_valid / column_ready   column
//   output    color_valid / color_ready     red, green, blue
//   config    psel, penable, pwrite         paddr, pwdata, prdata
//
// A transaction on the input passes through the locate, select, luma and color stages to the output.
// The four-stage pipeline takes one transaction per cycle while the output is not stalled.
// Each stage holds its contents while the stage after it is full and stalled.
// Reset clears every stage valid bit and the configuration registers to zero; stage data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module playfield_pixel_color (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                column_valid,
	output logic                     column_ready,
	input  wire pfpc_pkg::column_t   column,
	output logic                     color_valid,
	input  wire logic                color_ready,
	output pfpc_pkg::chan_t          red,
	output pfpc_pkg::chan_t          green,
	output pfpc_pkg::chan_t          blue
);
	import pfpc_pkg::*;

	pattern_t   pattern_q;
	logic       mirror_q;
	code_t      background_q;
	code_t      foreground_q;
	logic       write_en;
	logic [2:0] reg_index;

	logic       valid_s1;
	logic       ready_s1;
	index_t     index_s1;
	logic       on_line_s1;
	logic       valid_s2;
	logic       ready_s2;
	code_t      code_s2;

	assign pready    = 1'b1;
	assign write_en  = psel && penable && pwrite && pready;
	assign reg_index = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			mirror_q     <= 1'b0;
			background_q <= '0;
			foreground_q <= '0;
		end else if (write_en) begin
			unique case (reg_index)
				REG_PATTERN_LEFT:   pattern_q.left   <= pwdata[7:0];
				REG_PATTERN_MIDDLE: pattern_q.middle <= pwdata[7:0];
				REG_PATTERN_RIGHT:  pattern_q.right  <= pwdata[7:0];
				REG_MIRROR:         mirror_q         <= pwdata[0];
				REG_BACKGROUND:     background_q     <= pwdata[7:0];
				REG_FOREGROUND:     foreground_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_PATTERN_LEFT:   prdata = {24'd0, pattern_q.left};
			REG_PATTERN_MIDDLE: prdata = {24'd0, pattern_q.middle};
			REG_PATTERN_RIGHT:  prdata = {24'd0, pattern_q.right};
			REG_MIRROR:         prdata = {31'd0, mirror_q};
			REG_BACKGROUND:     prdata = {24'd0, background_q};
			REG_FOREGROUND:     prdata = {24'd0, foreground_q};
			default:            prdata = '0;
		endcase
	end

	pfpc_locate u_locate (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (column_valid),
		.in_ready   (column_ready),
		.column     (column),
		.mirror     (mirror_q),
		.out_valid  (valid_s1),
		.out_ready  (ready_s1),
		.index_s1   (index_s1),
		.on_line_s1 (on_line_s1)
	);

	pfpc_select u_select (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (valid_s1),
		.in_ready        (ready_s1),
		.index_s1        (index_s1),
		.on_line_s1      (on_line_s1),
		.pattern         (pattern_q),
		.background_code (background_q),
		.foreground_code (foreground_q),
		.out_valid       (valid_s2),
		.out_ready       (ready_s2),
		.code_s2         (code_s2)
	);

	pfpc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (ready_s2),
		.code_s2   (code_s2),
		.out_valid (color_valid),
		.out_ready (color_ready),
		.red_s4    (red),
		.green_s4  (green),
		.blue_s4   (blue)
	);

endmodule

`default_nettype wire
